// ----- rtl/llvs_pkg.sv -----
// Package for the LRU/LFU victim selector: command codes, register indexes,
// controller state type and the command/status structs between controller and datapath.
// No dependencies.
package llvs_pkg;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_TOUCH  = 2'd1;
  localparam logic [1:0] CMD_POP    = 2'd2;

  localparam logic CFG_POLICY_MODE  = 1'b0;
  localparam logic CFG_WEIGHT_LIMIT = 1'b1;

  localparam logic [7:0] WEIGHT_LIMIT_RESET = 8'd15;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_CAPTURE,
    ST_SWEEP,
    ST_UPDATE,
    ST_REMOVE,
    ST_REPLY
  } llvs_state_t;

  typedef struct packed {
    logic load_item;
    logic check;
    logic capture_s;
    logic sweep_start;
    logic write_s;
    logic remove_best;
    logic load_result;
  } llvs_ctl_t;

  typedef struct packed {
    logic bad;
    logic is_touch;
    logic is_pop;
    logic pass2;
    logic sweep_done;
    logic found;
    logic out_busy;
  } llvs_stat_t;

endpackage

// ----- rtl/lru_lfu_victim_selector.sv -----
// Top level of the LRU/LFU victim selector: controller plus datapath.
// Depends on llvs_pkg, llvs_ctrl, llvs_dp (and llvs_ram through llvs_dp).
//
//   channel | handshake            | payload
//   --------+----------------------+--------------------------------------------------
//   cfg     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//   in      | in_valid/in_ready    | cmd, slot, start_weight
//   out     | out_valid/out_ready  | victim_slot, victim_found, victim_weight, status
//
// Sweeps of the weight/rank RAM read one slot per cycle. A rejected command goes straight to
// the reply; insert and touch take one sweep, a pop a scan sweep and, with a victim, a second
// sweep. Reset clears the present bits at once, no clearing pass.
// One transaction is in work at a time; a held result stalls only the reply step.
module lru_lfu_victim_selector #(
  parameter int NUM_SLOTS   = 16,
  parameter int WEIGHT_BITS = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] cmd,
  input  logic [3:0] slot,
  input  logic [7:0] start_weight,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] victim_slot,
  output logic       victim_found,
  output logic [7:0] victim_weight,
  output logic       status
);
  import llvs_pkg::*;

  llvs_ctl_t  ctl;
  llvs_stat_t stat;

  llvs_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .stat    (stat),
    .ctl     (ctl)
  );

  llvs_dp #(
    .NUM_SLOTS  (NUM_SLOTS),
    .WEIGHT_BITS(WEIGHT_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .slot         (slot),
    .start_weight (start_weight),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .victim_slot  (victim_slot),
    .victim_found (victim_found),
    .victim_weight(victim_weight),
    .status       (status),
    .ctl          (ctl),
    .stat         (stat)
  );

endmodule

// ----- rtl/llvs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module llvs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/llvs_ctrl.sv -----
// Controller state machine of the victim selector: sequences check, sweeps and reply.
// Depends on llvs_pkg.
module llvs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  llvs_pkg::llvs_stat_t stat,
  output llvs_pkg::llvs_ctl_t  ctl
);
  import llvs_pkg::*;

  llvs_state_t state;
  llvs_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (stat.bad) state_next = ST_REPLY;
        else if (stat.is_touch) state_next = ST_CAPTURE;
        else state_next = ST_SWEEP;
      end
      ST_CAPTURE: state_next = ST_SWEEP;
      ST_SWEEP: begin
        if (stat.sweep_done) begin
          priority if (!stat.is_pop) state_next = ST_UPDATE;
          else if (stat.pass2 || !stat.found) state_next = ST_REPLY;
          else state_next = ST_REMOVE;
        end
      end
      ST_UPDATE: state_next = ST_REPLY;
      ST_REMOVE: state_next = ST_SWEEP;
      ST_REPLY: begin
        if (!stat.out_busy) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready      = 1'b1;
        ctl.load_item = in_valid;
      end
      ST_CHECK: begin
        ctl.check       = 1'b1;
        ctl.sweep_start = !stat.bad && !stat.is_touch;
      end
      ST_CAPTURE: begin
        ctl.capture_s   = 1'b1;
        ctl.sweep_start = 1'b1;
      end
      ST_SWEEP: ;
      ST_UPDATE: ctl.write_s = 1'b1;
      ST_REMOVE: begin
        ctl.remove_best = 1'b1;
        ctl.sweep_start = 1'b1;
      end
      ST_REPLY: ctl.load_result = !stat.out_busy;
      default: ;
    endcase
  end

endmodule

// ----- rtl/llvs_dp.sv -----
// Datapath of the victim selector: config registers, present bits, weight/rank RAM,
// sweep pipeline, victim search and output register. Depends on llvs_pkg and llvs_ram.
module llvs_dp #(
  parameter int NUM_SLOTS   = 16,
  parameter int WEIGHT_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic [1:0]           cmd,
  input  logic [3:0]           slot,
  input  logic [7:0]           start_weight,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [3:0]           victim_slot,
  output logic                 victim_found,
  output logic [7:0]           victim_weight,
  output logic                 status,
  input  llvs_pkg::llvs_ctl_t  ctl,
  output llvs_pkg::llvs_stat_t stat
);
  import llvs_pkg::*;

  localparam int SLOT_BITS = $clog2(NUM_SLOTS);
  localparam int RAM_WIDTH = WEIGHT_BITS + SLOT_BITS;
  localparam int WIDE      = (WEIGHT_BITS > 8) ? WEIGHT_BITS : 8;
  localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(NUM_SLOTS - 1);

  typedef enum logic [1:0] {
    SW_AGE_INSERT,
    SW_AGE_TOUCH,
    SW_SCAN,
    SW_AGE_POP
  } sweep_kind_t;

  logic                   policy_mode;
  logic [7:0]             weight_limit;
  logic [1:0]             item_cmd;
  logic [3:0]             item_slot;
  logic [7:0]             item_sw;
  logic                   item_rej;
  logic                   pass2;
  logic [NUM_SLOTS-1:0]   present;
  logic [WEIGHT_BITS-1:0] s_weight;
  logic [SLOT_BITS-1:0]   s_rank;
  logic                   issuing;
  logic [SLOT_BITS-1:0]   rd_cnt;
  logic                   pipe_valid;
  logic [SLOT_BITS-1:0]   pipe_addr;
  logic                   found;
  logic                   found_next;
  logic [SLOT_BITS-1:0]   best_idx;
  logic [SLOT_BITS-1:0]   best_idx_next;
  logic [WEIGHT_BITS-1:0] best_w;
  logic [WEIGHT_BITS-1:0] best_w_next;
  logic [SLOT_BITS-1:0]   best_rk;
  logic [SLOT_BITS-1:0]   best_rk_next;

  logic                   slot_ok;
  logic [SLOT_BITS-1:0]   slot_idx;
  logic                   present_s;
  logic                   is_insert;
  logic                   is_touch;
  logic                   is_pop;
  sweep_kind_t            kind;
  logic [WIDE-1:0]        lim_wide;
  logic [WIDE-1:0]        wmax_wide;
  logic [WIDE-1:0]        sw_wide;
  logic [WEIGHT_BITS-1:0] lim;
  logic [WEIGHT_BITS-1:0] new_weight;
  logic                   ram_we;
  logic [SLOT_BITS-1:0]   ram_waddr;
  logic [RAM_WIDTH-1:0]   ram_wdata;
  logic [SLOT_BITS-1:0]   ram_raddr;
  logic [RAM_WIDTH-1:0]   ram_rdata;
  logic [WEIGHT_BITS-1:0] p_w;
  logic [SLOT_BITS-1:0]   p_rk;
  logic                   p_present;
  logic                   age_we;
  logic [SLOT_BITS-1:0]   age_rank;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      policy_mode  <= 1'b0;
      weight_limit <= WEIGHT_LIMIT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_POLICY_MODE:  policy_mode  <= cfg_data[0];
        CFG_WEIGHT_LIMIT: weight_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  assign slot_ok   = 9'(item_slot) < 9'(NUM_SLOTS);
  assign slot_idx  = SLOT_BITS'(item_slot);
  assign present_s = slot_ok && present[slot_idx];
  assign is_insert = item_cmd == CMD_INSERT;
  assign is_touch  = item_cmd == CMD_TOUCH;
  assign is_pop    = item_cmd == CMD_POP;

  always_comb begin
    priority if (is_insert) kind = SW_AGE_INSERT;
    else if (is_touch) kind = SW_AGE_TOUCH;
    else if (!pass2) kind = SW_SCAN;
    else kind = SW_AGE_POP;
  end

  always_ff @(posedge clk) begin
    if (ctl.load_item) begin
      item_cmd  <= cmd;
      item_slot <= slot;
      item_sw   <= start_weight;
    end
    if (ctl.check) begin
      item_rej <= stat.bad;
    end
    if (ctl.capture_s) begin
      s_weight <= ram_rdata[SLOT_BITS +: WEIGHT_BITS];
      s_rank   <= ram_rdata[SLOT_BITS-1:0];
    end
    if (ctl.load_item) begin
      best_idx <= '0;
      best_w   <= '0;
      best_rk  <= '0;
    end else begin
      best_idx <= best_idx_next;
      best_w   <= best_w_next;
      best_rk  <= best_rk_next;
    end
    pipe_addr <= rd_cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pass2      <= 1'b0;
      found      <= 1'b0;
      issuing    <= 1'b0;
      rd_cnt     <= '0;
      pipe_valid <= 1'b0;
      present    <= '0;
    end else begin
      pipe_valid <= issuing;
      if (ctl.load_item) begin
        pass2 <= 1'b0;
        found <= 1'b0;
      end else begin
        found <= found_next;
        if (ctl.remove_best) pass2 <= 1'b1;
      end
      if (ctl.sweep_start) begin
        issuing <= 1'b1;
        rd_cnt  <= '0;
      end else if (issuing) begin
        if (rd_cnt == LAST_SLOT) issuing <= 1'b0;
        else rd_cnt <= rd_cnt + SLOT_BITS'(1);
      end
      if (ctl.write_s && is_insert) present[slot_idx] <= 1'b1;
      else if (ctl.remove_best) present[best_idx] <= 1'b0;
    end
  end

  // Effective limit and clamped insert weight
  assign wmax_wide = WIDE'({WEIGHT_BITS{1'b1}});
  assign lim_wide  = (WIDE'(weight_limit) < wmax_wide) ? WIDE'(weight_limit) : wmax_wide;
  assign sw_wide   = WIDE'(item_sw);
  assign lim       = WEIGHT_BITS'(lim_wide);

  always_comb begin
    new_weight = '0;
    if (policy_mode) begin
      if (is_insert) begin
        new_weight = WEIGHT_BITS'((sw_wide < lim_wide) ? sw_wide : lim_wide);
      end else begin
        new_weight = (s_weight < lim) ? s_weight + WEIGHT_BITS'(1) : lim;
      end
    end
  end

  assign p_w       = ram_rdata[SLOT_BITS +: WEIGHT_BITS];
  assign p_rk      = ram_rdata[SLOT_BITS-1:0];
  assign p_present = present[pipe_addr];

  always_comb begin
    age_we        = 1'b0;
    age_rank      = p_rk;
    found_next    = found;
    best_idx_next = best_idx;
    best_w_next   = best_w;
    best_rk_next  = best_rk;
    if (pipe_valid) begin
      unique case (kind)
        SW_AGE_INSERT: begin
          age_we   = p_present;
          age_rank = p_rk + SLOT_BITS'(1);
        end
        SW_AGE_TOUCH: begin
          age_we   = p_present && (pipe_addr != slot_idx) && (p_rk < s_rank);
          age_rank = p_rk + SLOT_BITS'(1);
        end
        SW_SCAN: begin
          if (p_present && (policy_mode || p_w == '0) &&
              (!found || p_w < best_w || (p_w == best_w && p_rk > best_rk))) begin
            found_next    = 1'b1;
            best_idx_next = pipe_addr;
            best_w_next   = p_w;
            best_rk_next  = p_rk;
          end
        end
        SW_AGE_POP: begin
          age_we   = p_present && (p_rk > best_rk);
          age_rank = p_rk - SLOT_BITS'(1);
        end
        default: ;
      endcase
    end
  end

  assign ram_we    = age_we || ctl.write_s;
  assign ram_waddr = ctl.write_s ? slot_idx : pipe_addr;
  assign ram_wdata = ctl.write_s ? {new_weight, SLOT_BITS'(0)} : {p_w, age_rank};
  assign ram_raddr = issuing ? rd_cnt : slot_idx;

  llvs_ram #(
    .WIDTH(RAM_WIDTH),
    .DEPTH(NUM_SLOTS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.load_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_result) begin
      victim_slot   <= found ? 4'(best_idx) : 4'd0;
      victim_found  <= found;
      victim_weight <= found ? 8'(best_w) : 8'd0;
      status        <= item_rej;
    end
  end

  assign stat.bad = !((is_insert && slot_ok && !present_s) ||
                      (is_touch && slot_ok && present_s) || is_pop);
  assign stat.is_touch   = is_touch;
  assign stat.is_pop     = is_pop;
  assign stat.pass2      = pass2;
  assign stat.sweep_done = pipe_valid && (pipe_addr == LAST_SLOT) && !issuing;
  assign stat.found      = found_next;
  assign stat.out_busy   = out_valid && !out_ready;

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for lru_lfu_victim_selector: random and directed insert/touch/pop
// traffic, with a cycle-free cache model predicting every reply. Depends on llvs_pkg and the RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import llvs_pkg::*;

  localparam logic [1:0] CMD_RSVD = 2'd3;
  localparam logic MODE_LRU = 1'b0;
  localparam logic MODE_LFU = 1'b1;
  localparam int SLOTS = 16;

  typedef struct packed {
    logic [1:0] op;
    logic [3:0] slot;
    logic [7:0] start_wt;
    logic       hold_off;
  } cache_cmd_t;

  typedef struct packed {
    logic [3:0] vslot;
    logic       found;
    logic [7:0] vweight;
    logic       rejected;
  } evict_reply_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_index = 1'b0;
  logic [7:0] cfg_data = 8'd0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] cmd = 2'd0;
  logic [3:0] slot = 4'd0;
  logic [7:0] start_weight = 8'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [3:0] victim_slot;
  logic       victim_found;
  logic [7:0] victim_weight;
  logic       status;

  lru_lfu_victim_selector dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .slot(slot), .start_weight(start_weight),
    .out_valid(out_valid), .out_ready(out_ready),
    .victim_slot(victim_slot), .victim_found(victim_found),
    .victim_weight(victim_weight), .status(status)
  );

  always #2 clk = ~clk;

  // cache model state and its copy of the registers
  logic       lfu_mode;
  logic [7:0] wt_limit;
  logic       held [SLOTS];
  logic [7:0] held_wt [SLOTS];
  logic [3:0] held_age [SLOTS];

  cache_cmd_t   cmd_backlog [$];
  evict_reply_t replies_due [$];
  int results_owed = 0;
  int mismatches = 0;
  logic in_acc = 1'b0;
  int burst_left = 1;
  int gap_left = 0;

  function automatic evict_reply_t cache_response(cache_cmd_t c);
    evict_reply_t r;
    int best;
    logic hit;
    logic [3:0] old_age;
    r = '0;
    best = 0;
    hit = 1'b0;
    unique case (c.op)
      CMD_INSERT: begin
        if (held[c.slot]) begin
          r.rejected = 1'b1;
        end else begin
          held_wt[c.slot] = lfu_mode ? ((c.start_wt < wt_limit) ? c.start_wt : wt_limit) : 8'd0;
          for (int i = 0; i < SLOTS; i++)
            if (held[i]) held_age[i] = held_age[i] + 4'd1;
          held_age[c.slot] = 4'd0;
          held[c.slot] = 1'b1;
        end
      end
      CMD_TOUCH: begin
        if (!held[c.slot]) begin
          r.rejected = 1'b1;
        end else begin
          if (lfu_mode)
            held_wt[c.slot] = (held_wt[c.slot] < wt_limit) ? held_wt[c.slot] + 8'd1 : wt_limit;
          else
            held_wt[c.slot] = 8'd0;
          old_age = held_age[c.slot];
          for (int i = 0; i < SLOTS; i++)
            if (i != c.slot && held[i] && held_age[i] < old_age) held_age[i] = held_age[i] + 4'd1;
          held_age[c.slot] = 4'd0;
        end
      end
      CMD_POP: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (held[i] && (lfu_mode || held_wt[i] == 8'd0)) begin
            if (!hit || held_wt[i] < held_wt[best] ||
                (held_wt[i] == held_wt[best] && held_age[i] > held_age[best])) begin
              best = i;
              hit = 1'b1;
            end
          end
        end
        if (hit) begin
          old_age = held_age[best];
          r.vslot = best[3:0];
          r.found = 1'b1;
          r.vweight = held_wt[best];
          held[best] = 1'b0;
          held_wt[best] = 8'd0;
          held_age[best] = 4'd0;
          for (int i = 0; i < SLOTS; i++)
            if (held[i] && held_age[i] > old_age) held_age[i] = held_age[i] - 4'd1;
        end
      end
      default: r.rejected = 1'b1;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (mismatches < 40)
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    mismatches++;
  endtask

  // drive the command channel in bursts
  always @(negedge clk) begin
    cache_cmd_t nxt;
    logic send;
    send = 1'b0;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_acc) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (cmd_backlog.size() > 0 &&
                   !(cmd_backlog[0].hold_off && replies_due.size() > 0)) begin
        nxt = cmd_backlog.pop_front();
        send = 1'b1;
        cmd <= nxt.op;
        slot <= nxt.slot;
        start_weight <= nxt.start_wt;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 :
                      (($urandom_range(0, 4) == 0) ? $urandom_range(10, 45) : $urandom_range(1, 9));
        end else begin
          burst_left <= burst_left - 1;
        end
      end
      in_valid <= send;
    end
  end

  // result back-pressure
  logic [7:0] ready_mask = 8'hFF;
  int mask_pos = 0;
  int mask_life = 0;
  always @(negedge clk) begin
    if (mask_life == 0) begin
      mask_life <= $urandom_range(16, 96);
      ready_mask <= ($urandom_range(0, 2) == 0) ? 8'hFF : (8'($urandom_range(0, 255)) | 8'h01);
    end else begin
      mask_life <= mask_life - 1;
    end
    mask_pos <= (mask_pos + 1) % 8;
    out_ready <= ready_mask[mask_pos];
  end

  // monitor: check replies, then predict for the accepted command
  always @(posedge clk) begin
    evict_reply_t want;
    cache_cmd_t got_cmd;
    in_acc <= in_valid && in_ready && !rst;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_POLICY_MODE) lfu_mode = cfg_data[0];
        else wt_limit = cfg_data;
      end
      if (out_valid && out_ready) begin
        if (replies_due.size() == 0) begin
          report_mismatch("unexpected transaction, victim_slot", int'(victim_slot), 0);
        end else begin
          want = replies_due.pop_front();
          results_owed--;
          if (victim_slot !== want.vslot)
            report_mismatch("victim_slot", int'(victim_slot), int'(want.vslot));
          if (victim_found !== want.found)
            report_mismatch("victim_found", int'(victim_found), int'(want.found));
          if (victim_weight !== want.vweight)
            report_mismatch("victim_weight", int'(victim_weight), int'(want.vweight));
          if (status !== want.rejected)
            report_mismatch("status", int'(status), int'(want.rejected));
        end
      end
      if (in_valid && in_ready) begin
        got_cmd = '0;
        got_cmd.op = cmd;
        got_cmd.slot = slot;
        got_cmd.start_wt = start_weight;
        replies_due.push_back(cache_response(got_cmd));
      end
    end
  end

  task automatic add_cmd(logic [1:0] op, logic [3:0] s, logic [7:0] sw, logic hold = 1'b0);
    cache_cmd_t c;
    c.op = op;
    c.slot = s;
    c.start_wt = sw;
    c.hold_off = hold;
    results_owed++;
    cmd_backlog.push_back(c);
  endtask

  task automatic add_random(int n, int hi);
    int pick;
    int sel;
    logic [1:0] op;
    logic [7:0] sw;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      op = (pick < 38) ? CMD_INSERT : (pick < 72) ? CMD_TOUCH : (pick < 95) ? CMD_POP : CMD_RSVD;
      sel = $urandom_range(0, 3);
      sw = (sel == 0) ? 8'($urandom_range(0, 255)) :
           (sel == 1) ? 8'($urandom_range(250, 255)) : 8'($urandom_range(0, 8));
      add_cmd(op, 4'($urandom_range(0, hi)), sw, $urandom_range(0, 199) == 0);
    end
  endtask

  task automatic write_reg(logic idx, logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_config(logic mode, logic [7:0] lim);
    write_reg(CFG_POLICY_MODE, {7'd0, mode});
    write_reg(CFG_WEIGHT_LIMIT, lim);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain_all();
    while (results_owed != 0) @(negedge clk);
  endtask

  initial begin
    int lim;
    lfu_mode = MODE_LRU;
    wt_limit = WEIGHT_LIMIT_RESET;
    for (int i = 0; i < SLOTS; i++) begin
      held[i] = 1'b0;
      held_wt[i] = 8'd0;
      held_age[i] = 4'd0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    set_config(MODE_LRU, WEIGHT_LIMIT_RESET);
    add_cmd(CMD_POP, 4'd0, 8'd0);
    add_cmd(CMD_TOUCH, 4'd5, 8'd0);
    add_cmd(CMD_RSVD, 4'd15, 8'd255);
    add_cmd(CMD_INSERT, 4'd0, 8'd255);
    add_cmd(CMD_INSERT, 4'd15, 8'd0);
    add_cmd(CMD_INSERT, 4'd7, 8'd9);
    add_cmd(CMD_INSERT, 4'd0, 8'd1);
    add_cmd(CMD_TOUCH, 4'd0, 8'd0);
    add_cmd(CMD_POP, 4'd3, 8'd0);
    add_cmd(CMD_POP, 4'd0, 8'd0, 1'b1);
    drain_all();

    set_config(MODE_LFU, 8'd255);
    add_cmd(CMD_INSERT, 4'd3, 8'd255);
    add_cmd(CMD_INSERT, 4'd4, 8'd0);
    add_cmd(CMD_INSERT, 4'd9, 8'd254);
    add_cmd(CMD_TOUCH, 4'd9, 8'd0);
    add_cmd(CMD_TOUCH, 4'd3, 8'd0);
    add_cmd(CMD_TOUCH, 4'd4, 8'd0);
    add_cmd(CMD_POP, 4'd0, 8'd0, 1'b1);
    drain_all();

    set_config(MODE_LFU, 8'd2);
    add_cmd(CMD_TOUCH, 4'd3, 8'd0);
    add_cmd(CMD_INSERT, 4'd12, 8'd200);
    add_cmd(CMD_POP, 4'd0, 8'd0);
    drain_all();

    set_config(MODE_LRU, 8'd0);
    add_cmd(CMD_POP, 4'd0, 8'd0);
    add_cmd(CMD_INSERT, 4'd8, 8'd77);
    add_cmd(CMD_POP, 4'd0, 8'd0);
    drain_all();

    for (int p = 0; p < 8; p++) begin
      lim = (p == 1) ? 0 : (p == 3) ? 255 : (p == 5) ? 1 : $urandom_range(0, 255);
      set_config((p % 2) ? MODE_LFU : MODE_LRU, lim[7:0]);
      add_random(150, ($urandom_range(0, 2) == 0) ? 7 : 15);
      drain_all();
    end

    repeat (64) @(negedge clk);
    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
